// File: src/pbrb_pkg.sv
// ----------------------------------------------------------------------------
// PCM playback ring buffer - shared package
// Types, register indexes, reset values and arithmetic constants.
// ----------------------------------------------------------------------------
package pbrb_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREROLL = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD   = 8'd3;

    localparam logic [7:0]  VOLUME_RESET  = 8'd10;
    localparam logic        CHANNEL_RESET = 1'b0;
    localparam logic [11:0] PREROLL_RESET = 12'd1024;
    localparam logic [11:0] GUARD_RESET   = 12'd32;

    // item kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // divide by 100: magnitude below 2^23 times ceil(2^30/100), then >> 30
    localparam int          DIV_SHIFT = 30;
    localparam logic [23:0] DIV_RECIP = 24'd10737419;
    localparam int          QUOT_W    = 17;

    // 16-bit saturation limits, as magnitudes
    localparam logic [QUOT_W-1:0] SAT_POS_MAG = 17'd32767;
    localparam logic [QUOT_W-1:0] SAT_NEG_MAG = 17'd32768;
    localparam logic signed [15:0] SAT_POS = 16'sd32767;
    localparam logic signed [15:0] SAT_NEG = -16'sd32768;

    // fill level saturation
    localparam int              FILL_W   = 13;
    localparam logic [FILL_W-1:0] FILL_MAX = 13'd8191;

    // a push writes two halfwords and needs that much free space
    localparam logic [32:0] PUSH_WORDS = 33'd2;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic              kind;
        logic signed [15:0] sample_a;
        logic signed [15:0] sample_b;
        logic              end_of_block;
    } t_in_item;

    typedef struct packed {
        logic              accepted;
        logic              underrun_recovered;
        logic signed [15:0] drain_sample;
        logic [FILL_W-1:0] fill_level;
        logic              block_done;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  volume_percent;
        logic        channel_mode;
        logic [11:0] preroll_words;
        logic [11:0] guard_words;
    } t_cfg;

    // classified job handed from front to back
    typedef struct packed {
        logic              kind;
        logic signed [15:0] sample;
        logic              end_of_block;
    } t_job;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_job job;
    } t_q_head;

endpackage

// File: src/pbrb_front.sv
// ----------------------------------------------------------------------------
// PCM playback ring buffer - front end
// Accepts items, mixes stereo to mono and applies gain with saturation.
// ----------------------------------------------------------------------------
module pbrb_front
    import pbrb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    input  logic     i_q_full,
    output logic     o_push,
    output t_job     o_job
);

    logic r_v1, r_v2, r_v3;
    logic n_v1, n_v2, n_v3;
    logic en;

    logic              r_kind1, r_kind2, r_kind3;
    logic              r_eob1, r_eob2, r_eob3;
    logic              r_neg1, r_neg2, r_neg3;
    logic [15:0]       r_mag1;
    logic [22:0]       r_m2;
    logic [QUOT_W-1:0] r_q3;

    logic signed [16:0] sum;
    logic signed [16:0] sum_adj;
    logic signed [16:0] avg;
    logic signed [15:0] sel;
    logic [15:0]        mag;
    logic [23:0]        vprod;
    logic [46:0]        qprod;
    logic signed [15:0] sat;

    // advance the whole pipe unless the last stage is blocked by a full queue
    assign en         = !r_v3 || !i_q_full;
    assign o_in_stall = !en;
    assign o_push     = r_v3 && !i_q_full;

    // stage 1: stereo average truncated toward zero, then sign and magnitude
    always_comb begin
        sum     = 17'(i_in_data.sample_a) + 17'(i_in_data.sample_b);
        sum_adj = sum + $signed({16'b0, sum[16]});
        avg     = sum_adj >>> 1;
        sel     = i_cfg.channel_mode ? avg[15:0] : i_in_data.sample_a;
        mag     = sel[15] ? (~sel + 16'd1) : sel;
    end

    // stage 2: gain; stage 3: divide by 100 through the reciprocal
    assign vprod = r_mag1 * i_cfg.volume_percent;
    assign qprod = r_m2 * DIV_RECIP;

    // saturate the quotient back to a signed halfword
    always_comb begin
        if (r_neg3) begin
            sat = (r_q3 > SAT_NEG_MAG) ? SAT_NEG : 16'(~r_q3 + 17'd1);
        end else begin
            sat = (r_q3 > SAT_POS_MAG) ? SAT_POS : r_q3[15:0];
        end
        o_job.kind         = r_kind3;
        o_job.sample       = (r_kind3 == KIND_TICK) ? 16'sd0 : sat;
        o_job.end_of_block = r_eob3;
    end

    always_comb begin
        n_v1 = en ? i_in_valid : r_v1;
        n_v2 = en ? r_v1 : r_v2;
        n_v3 = en ? r_v2 : r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_kind1 <= i_in_data.kind;
            r_eob1  <= i_in_data.end_of_block;
            r_neg1  <= sel[15];
            r_mag1  <= mag;
            r_kind2 <= r_kind1;
            r_eob2  <= r_eob1;
            r_neg2  <= r_neg1;
            r_m2    <= vprod[22:0];
            r_kind3 <= r_kind2;
            r_eob3  <= r_eob2;
            r_neg3  <= r_neg2;
            r_q3    <= qprod[DIV_SHIFT +: QUOT_W];
        end
    end

endmodule

// File: src/pbrb_queue.sv
// ----------------------------------------------------------------------------
// PCM playback ring buffer - job queue
// Short FIFO that lets the front end and the back end stall independently.
// ----------------------------------------------------------------------------
module pbrb_queue
    import pbrb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    output logic    o_full,
    input  logic    i_pop,
    output t_q_head o_head
);

    t_job            r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;
    logic [Q_AW-1:0] n_wp, n_rp;
    logic [Q_AW:0]   n_cnt;
    logic            do_pop;

    assign o_full      = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.job   = r_slot[r_rp];
    assign do_pop       = i_pop && o_head.valid;

    // advance pointers and occupancy
    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // store the incoming job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

endmodule

// File: src/pbrb_back.sv
// ----------------------------------------------------------------------------
// PCM playback ring buffer - back end
// Owns the halfword store and the write/read totals; runs underrun recovery,
// space checks, the two halfword writes of a push and the reads of a tick.
// ----------------------------------------------------------------------------
module pbrb_back
    import pbrb_pkg::*;
#(
    parameter int RING_DEPTH = 4096
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_q_head   i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int AW = $clog2(RING_DEPTH);

    typedef enum logic [5:0] {
        ST_CLR  = 6'b000001,
        ST_IDLE = 6'b000010,
        ST_EXE  = 6'b000100,
        ST_CHK  = 6'b001000,
        ST_WR1  = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    t_state r_st, n_st;
    logic [AW-1:0] r_clr_cnt, n_clr_cnt;
    logic          r_resume, n_resume;
    logic [31:0]   r_w, n_w;
    logic [31:0]   r_r, n_r;
    logic          r_out_vld, n_out_vld;

    t_job      r_job;
    logic      r_acc, r_rec, r_done;
    logic      n_acc, n_rec, n_done;
    t_out_item r_out_data, n_out_data;

    logic signed [15:0] r_mem [RING_DEPTH];
    logic signed [15:0] r_rd_data;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_wa;
    logic signed [15:0] mem_wd;

    logic [31:0] used;
    logic [32:0] cap;
    logic        refuse;
    logic        out_load;

    // used halfwords and push space check
    always_comb begin
        used   = (r_w > r_r) ? (r_w - r_r) : 32'd0;
        cap    = 33'(RING_DEPTH) - 33'(i_cfg.guard_words);
        refuse = (33'(i_cfg.guard_words) >= 33'(RING_DEPTH)) ||
                 (({1'b0, used} + PUSH_WORDS) > cap);
    end

    assign out_load = (r_st == ST_FIN) && (!r_out_vld || !i_out_stall);
    assign o_pop    = (r_st == ST_IDLE) && i_head.valid;

    // sequencer
    always_comb begin
        n_st      = r_st;
        n_clr_cnt = r_clr_cnt;
        n_resume  = r_resume;
        n_w       = r_w;
        n_r       = r_r;
        n_acc     = r_acc;
        n_rec     = r_rec;
        n_done    = r_done;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wa    = r_w[AW-1:0];
        mem_wd    = r_job.sample;
        unique case (r_st)
            ST_CLR: begin
                mem_we    = 1'b1;
                mem_wa    = r_clr_cnt;
                mem_wd    = 16'sd0;
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == AW'(RING_DEPTH - 1)) begin
                    n_st = r_resume ? ST_CHK : ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_acc  = 1'b1;
                n_rec  = 1'b0;
                n_done = 1'b0;
                if (i_head.valid) begin
                    n_st = ST_EXE;
                end
            end
            ST_EXE: begin
                if (r_job.kind == KIND_TICK) begin
                    mem_re = 1'b1;
                    n_r    = r_r + 32'd1;
                    n_st   = ST_FIN;
                end else if (r_w <= r_r) begin
                    // underrun: reopen ahead of the reader and wipe the store
                    n_w       = r_r + 32'(i_cfg.preroll_words);
                    n_rec     = 1'b1;
                    n_clr_cnt = '0;
                    n_resume  = 1'b1;
                    n_st      = ST_CLR;
                end else begin
                    n_st = ST_CHK;
                end
            end
            ST_CHK: begin
                if (refuse) begin
                    n_acc = 1'b0;
                    n_st  = ST_FIN;
                end else begin
                    mem_we = 1'b1;
                    n_w    = r_w + 32'd1;
                    n_st   = ST_WR1;
                end
            end
            ST_WR1: begin
                mem_we = 1'b1;
                n_w    = r_w + 32'd1;
                n_done = r_job.end_of_block;
                n_st   = ST_FIN;
            end
            ST_FIN: begin
                if (out_load) begin
                    n_st = ST_IDLE;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    // result register: load on completion, drop once taken
    always_comb begin
        n_out_data.accepted           = r_acc;
        n_out_data.underrun_recovered = r_rec;
        n_out_data.drain_sample       = (r_job.kind == KIND_TICK) ? r_rd_data : 16'sd0;
        n_out_data.fill_level         = (|used[31:FILL_W]) ? FILL_MAX : used[FILL_W-1:0];
        n_out_data.block_done         = r_done;
        if (out_load) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_CLR;
            r_clr_cnt <= '0;
            r_resume  <= 1'b0;
            r_w       <= 32'(PREROLL_RESET);
            r_r       <= 32'd0;
            r_out_vld <= 1'b0;
        end else begin
            r_st      <= n_st;
            r_clr_cnt <= n_clr_cnt;
            r_resume  <= n_resume;
            r_w       <= n_w;
            r_r       <= n_r;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head.job;
        end
        r_acc  <= n_acc;
        r_rec  <= n_rec;
        r_done <= n_done;
        if (out_load) begin
            r_out_data <= n_out_data;
        end
    end

    // halfword store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_r[AW-1:0]];
        end
    end

    // a finished result is never dropped while a new one is loaded
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |-> !out_load)
        else $error("result overwritten while stalled");

    // the second halfword write advances the write total by one
    a_wr1_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_WR1) |=> (r_w == $past(r_w) + 32'd1))
        else $error("write total did not advance");

    // the clear pass only ends after the last entry
    a_clr_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_CLR && n_st != ST_CLR) |-> (r_clr_cnt == AW'(RING_DEPTH - 1)))
        else $error("clear pass ended early");

    // a refused push never reports end of block
    a_refused_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !n_out_data.accepted) |-> !n_out_data.block_done)
        else $error("block_done on refused push");

    // nothing is popped while a job is still in progress
    a_single_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_st == ST_EXE))
        else $error("pop without starting a job");

endmodule

// File: src/pcm_playback_ring_buffer_top.sv
// ----------------------------------------------------------------------------
// PCM playback ring buffer - top level
// Configuration registers and the front end, queue and back end.
// ----------------------------------------------------------------------------
// Push beats carry one mono sample or a stereo pair; the front end averages,
// scales by volume_percent/100 and saturates in a three-stage pipe, and the
// back end writes the sample twice into a RING_DEPTH-halfword store. A drain
// tick steps through dequeue, memory read and result in the back end; a push
// through dequeue, underrun check, space check with first write, second write
// and result, and a refused push goes from the space check to the result.
// A push that finds an underrun adds a clearing pass over all RING_DEPTH
// entries, and after reset the same pass runs before the first item
// is processed (items are still queued, configuration writes still taken).
// RING_DEPTH must be a power of two. One result beat is returned per item,
// in order; the front pipe and a four-entry queue keep accepting while a
// result waits, until both are full.
module pcm_playback_ring_buffer_top
    import pbrb_pkg::*;
#(
    parameter int RING_DEPTH = 4096
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg, n_cfg;
    logic    q_push, q_full, q_pop;
    t_job    q_job;
    t_q_head q_head;

    assign o_cfg_ready = 1'b1;

    // register writes; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VOLUME:  n_cfg.volume_percent = i_cfg_data[7:0];
                CFG_CHANNEL: n_cfg.channel_mode   = i_cfg_data[0];
                CFG_PREROLL: n_cfg.preroll_words  = i_cfg_data[11:0];
                CFG_GUARD:   n_cfg.guard_words    = i_cfg_data[11:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.volume_percent <= VOLUME_RESET;
            r_cfg.channel_mode   <= CHANNEL_RESET;
            r_cfg.preroll_words  <= PREROLL_RESET;
            r_cfg.guard_words    <= GUARD_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    pbrb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (q_job)
    );

    pbrb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    pbrb_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
